// ===== sv/kvms_pkg.sv =====
// Package for the key-value map store: command and status codes,
// the input and result item structs and the controller-to-datapath command struct.
// No dependencies.
package kvms_pkg;

  // Default number of entries in the store
  localparam int DEFAULT_CAPACITY = 64;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;

  // Command codes
  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // One command item
  typedef struct packed {
    cmd_t                 cmd;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
  } in_item_t;

  // One result item
  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   read_value;
  } out_item_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;   // capture the item and the lookup results
    logic exec;   // update the entries, issue the value read
  } dp_ctrl_t;

endpackage

// ===== sv/key_value_map_store.sv =====
// Top level of the key-value map store: controller plus datapath.
// Depends on kvms_pkg, kvms_ctrl and kvms_dpath.
//
// Usage:
//   Command channel: drive in_payload (cmd, key, value) and raise start; the
//   command transfers at a rising edge where start is high and busy is low.
//   Commands: set, delete, get, clear all entries.
//   Result channel: out_valid is high for exactly one cycle with out_payload
//   (status, read_value). The receiver cannot stall; it must take the result.
//   The cycle after the transfer runs the entry update or value read; the
//   next shows the result. The key compare of all entries happens in the
//   transfer cycle; the value memory write or read happens in the execute
//   cycle. The block takes no new command while busy in the execute cycle.
//   busy is low again while the result is on the ports, so the next command
//   may transfer in that same cycle.
//   Reset (synchronous, active low): all entries become invalid at once and
//   any command in flight is dropped; no clearing pass is needed.
module key_value_map_store #(
  parameter int CAPACITY = kvms_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kvms_pkg::in_item_t  in_payload,
  output logic                out_valid,
  output kvms_pkg::out_item_t out_payload
);

  kvms_pkg::dp_ctrl_t ctrl;

  kvms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .ctrl      (ctrl),
    .out_valid (out_valid)
  );

  kvms_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_item  (in_payload),
    .out_item (out_payload)
  );

endmodule

// ===== sv/kvms_ctrl.sv =====
// Controller for the key-value map store: two-state sequencer that accepts a
// command, runs the execute step and raises the result strobe.
// Depends on kvms_pkg.
module kvms_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output kvms_pkg::dp_ctrl_t ctrl,
  output logic               out_valid
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign ctrl.load = start && (state_r == S_IDLE);
  assign ctrl.exec = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/kvms_dpath.sv =====
// Datapath for the key-value map store: key CAM with valid bits, value memory,
// parallel match and lowest-free search, result registers.
// Depends on kvms_pkg.
module kvms_dpath #(
  parameter int CAPACITY = kvms_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kvms_pkg::dp_ctrl_t  ctrl,
  input  kvms_pkg::in_item_t  in_item,
  output kvms_pkg::out_item_t out_item
);

  localparam int IDX_W = $clog2(CAPACITY);

  // Entry storage
  logic [CAPACITY-1:0]            valid_r;
  logic [kvms_pkg::KEY_W-1:0]     entry_key_r [CAPACITY];
  logic [kvms_pkg::VALUE_W-1:0]   entry_value_mem [CAPACITY];

  // Captured command
  kvms_pkg::cmd_t                 cmd_r;
  logic [kvms_pkg::KEY_W-1:0]     key_r;
  logic [kvms_pkg::VALUE_W-1:0]   value_r;
  logic                           hit_r;
  logic [IDX_W-1:0]               hit_idx_r;
  logic                           free_r;
  logic [IDX_W-1:0]               free_idx_r;

  // Result registers
  kvms_pkg::status_t              status_r;
  logic                           use_mem_r;
  logic                           ones_r;
  logic [kvms_pkg::VALUE_W-1:0]   rd_data_r;

  // Lookup
  logic [CAPACITY-1:0]            match;
  logic [CAPACITY-1:0]            free_vec;
  logic [CAPACITY-1:0]            free_low;
  logic [IDX_W-1:0]               hit_idx;
  logic [IDX_W-1:0]               free_idx;

  logic                           set_we;
  logic                           get_re;
  logic [IDX_W-1:0]               widx;

  // Parallel key compare against the incoming item; at most one entry matches
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid_r[i] && (entry_key_r[i] == in_item.key);
      if (match[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  // Lowest free entry: isolate the lowest set bit, then encode
  assign free_vec = ~valid_r;
  assign free_low = free_vec & (~free_vec + CAPACITY'(1));

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (free_low[i]) free_idx = free_idx | IDX_W'(i);
    end
  end

  // Capture item and lookup at transfer
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r      <= in_item.cmd;
      key_r      <= in_item.key;
      value_r    <= in_item.value;
      hit_r      <= |match;
      hit_idx_r  <= hit_idx;
      free_r     <= |free_vec;
      free_idx_r <= free_idx;
    end
  end

  assign set_we = ctrl.exec && (cmd_r == kvms_pkg::CMD_SET) && (hit_r || free_r);
  assign get_re = ctrl.exec && (cmd_r == kvms_pkg::CMD_GET) && hit_r;
  assign widx   = hit_r ? hit_idx_r : free_idx_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctrl.exec) begin
      unique case (cmd_r)
        kvms_pkg::CMD_SET: begin
          if (hit_r || free_r) valid_r[widx] <= 1'b1;
        end
        kvms_pkg::CMD_DELETE: begin
          if (hit_r) valid_r[hit_idx_r] <= 1'b0;
        end
        kvms_pkg::CMD_GET: begin
        end
        kvms_pkg::CMD_CLEAR: begin
          valid_r <= '0;
        end
      endcase
    end
  end

  // Key cells
  always_ff @(posedge clk) begin
    if (set_we) entry_key_r[widx] <= key_r;
  end

  // Value memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (set_we) entry_value_mem[widx] <= value_r;
    if (get_re) rd_data_r <= entry_value_mem[hit_idx_r];
  end

  // Result status and read-value selection
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      use_mem_r <= 1'b0;
      ones_r    <= 1'b0;
      status_r  <= kvms_pkg::ST_OK;
      unique case (cmd_r)
        kvms_pkg::CMD_SET: begin
          if (!(hit_r || free_r)) status_r <= kvms_pkg::ST_FULL;
        end
        kvms_pkg::CMD_DELETE: begin
          if (!hit_r) status_r <= kvms_pkg::ST_NOT_FOUND;
        end
        kvms_pkg::CMD_GET: begin
          if (hit_r) begin
            use_mem_r <= 1'b1;
          end else begin
            status_r <= kvms_pkg::ST_NOT_FOUND;
            ones_r   <= 1'b1;
          end
        end
        kvms_pkg::CMD_CLEAR: begin
        end
      endcase
    end
  end

  assign out_item.status     = status_r;
  assign out_item.read_value = use_mem_r ? rd_data_r : {kvms_pkg::VALUE_W{ones_r}};

endmodule

// ===== sv/kvms_checker.sv =====
// Port-level checker for the key-value map store, bound to the top level.
// Depends on kvms_pkg and key_value_map_store.
module kvms_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input kvms_pkg::in_item_t  in_payload,
  input logic                out_valid,
  input kvms_pkg::out_item_t out_payload
);

  // A transfer makes the block busy for the execute cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // The execute cycle is followed by exactly one result and a free block
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("no result after execute cycle");

  // Results only appear following a busy cycle
  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !out_valid) |=> !out_valid)
    else $error("result without a command");

  // Clear always succeeds with a zero read value
  a_clear_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_payload.cmd == kvms_pkg::CMD_CLEAR)) |-> ##2
    (out_valid && (out_payload.status == kvms_pkg::ST_OK) && (out_payload.read_value == '0)))
    else $error("clear result wrong");

  // A full store reports a zero read value
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_payload.status == kvms_pkg::ST_FULL)) |-> (out_payload.read_value == '0))
    else $error("full status with nonzero read value");

endmodule

bind key_value_map_store kvms_checker u_kvms_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for key_value_map_store: drives set/delete/get/clear
// commands and checks every result against an in-bench model of the entry table.
// Depends on kvms_pkg and key_value_map_store.
module tb_top;

  localparam int SLOTS       = kvms_pkg::DEFAULT_CAPACITY;
  localparam int RAND_ITEMS  = 850;
  localparam int MAX_REPORTS = 50;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  kvms_pkg::in_item_t  in_payload = '0;
  logic                out_valid;
  kvms_pkg::out_item_t out_payload;

  key_value_map_store #(.CAPACITY(SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Commands waiting to be sent; hold_for_drain makes the sender wait until
  // every earlier result has come back.
  typedef struct {
    kvms_pkg::in_item_t cmd;
    bit                 hold_for_drain;
  } queued_cmd_t;

  queued_cmd_t cmd_queue[$];
  logic [31:0] key_pool[$];

  // Shadow of the entry table
  bit          map_valid [SLOTS];
  logic [31:0] map_key   [SLOTS];
  logic [63:0] map_value [SLOTS];

  // Predicted results, indexed by transfer number
  kvms_pkg::out_item_t expected_replies [int];
  int                  sent_cnt = 0;
  int                  rcv_cnt = 0;
  int                  err_cnt = 0;
  int                  gap_left = 0;
  bit                  burst = 1'b0;
  kvms_pkg::out_item_t want;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Lowest valid entry holding the key, or -1
  function automatic int lookup_key(logic [31:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (map_valid[i] && map_key[i] == key) return i;
    return -1;
  endfunction

  function automatic kvms_pkg::out_item_t apply_command(kvms_pkg::in_item_t c);
    kvms_pkg::out_item_t r;
    int                  hit;
    r.status     = kvms_pkg::ST_OK;
    r.read_value = '0;
    hit          = lookup_key(c.key);
    case (c.cmd)
      kvms_pkg::CMD_SET: begin
        // overwrite a present key, else take the lowest free entry
        if (hit < 0) begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!map_valid[i]) hit = i;
        end
        if (hit < 0) begin
          r.status = kvms_pkg::ST_FULL;
        end else begin
          map_valid[hit] = 1'b1;
          map_key[hit]   = c.key;
          map_value[hit] = c.value;
        end
      end
      kvms_pkg::CMD_DELETE: begin
        if (hit < 0) r.status = kvms_pkg::ST_NOT_FOUND;
        else map_valid[hit] = 1'b0;
      end
      kvms_pkg::CMD_GET: begin
        if (hit < 0) begin
          r.status     = kvms_pkg::ST_NOT_FOUND;
          r.read_value = '1;
        end else begin
          r.read_value = map_value[hit];
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) map_valid[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_cmd(kvms_pkg::cmd_t op, logic [31:0] key, logic [63:0] value,
                          bit drain);
    queued_cmd_t q;
    q.cmd.cmd      = op;
    q.cmd.key      = key;
    q.cmd.value    = value;
    q.hold_for_drain = drain;
    cmd_queue.push_back(q);
  endtask

  // Mostly full-range values, with zero and all ones mixed in
  function automatic logic [63:0] rand_value();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] fresh_key();
    int sel;
    sel = $urandom_range(0, 31);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Mostly keys from the pool so commands hit; some strays that miss
  function automatic logic [31:0] pick_key();
    if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) return fresh_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // Random mix of commands over a key pool of random size
  task automatic mix_session(int len, int pool_size);
    int             w;
    kvms_pkg::cmd_t op;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.push_back(fresh_key());
    for (int i = 0; i < len; i++) begin
      w = $urandom_range(0, 99);
      if (w < 40)      op = kvms_pkg::CMD_SET;
      else if (w < 70) op = kvms_pkg::CMD_GET;
      else if (w < 97) op = kvms_pkg::CMD_DELETE;
      else             op = kvms_pkg::CMD_CLEAR;
      push_cmd(op, pick_key(), rand_value(), i == 0 || $urandom_range(0, 49) == 0);
    end
  endtask

  // Clear, fill the store past capacity, then poke at the full store
  task automatic fill_session();
    logic [31:0] k;
    push_cmd(kvms_pkg::CMD_CLEAR, fresh_key(), rand_value(), 1'b1);
    key_pool.delete();
    for (int i = 0; i < SLOTS + $urandom_range(1, 8); i++) begin
      k = fresh_key();
      key_pool.push_back(k);
      push_cmd(kvms_pkg::CMD_SET, k, rand_value(), 1'b0);
    end
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(0, 3))
        0:       push_cmd(kvms_pkg::CMD_SET, fresh_key(), rand_value(), 1'b0);
        1:       push_cmd(kvms_pkg::CMD_DELETE, pick_key(), rand_value(), 1'b0);
        2:       push_cmd(kvms_pkg::CMD_SET, pick_key(), rand_value(), 1'b0);
        default: push_cmd(kvms_pkg::CMD_GET, pick_key(), rand_value(), 1'b0);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one command per transfer, random gaps with idle-free stretches
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      in_payload <= '0;
      sent_cnt   <= 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        expected_replies[sent_cnt] = apply_command(in_payload);
        sent_cnt <= sent_cnt + 1;
      end
      if (start && busy) begin
        // hold the command until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() > 0 &&
                   !(cmd_queue[0].hold_for_drain &&
                     ((start && !busy) || sent_cnt != rcv_cnt))) begin
        in_payload <= cmd_queue[0].cmd;
        start      <= 1'b1;
        void'(cmd_queue.pop_front());
        if ($urandom_range(0, 39) == 0) burst = !burst;
        gap_left = burst ? 0 : $urandom_range(0, 18);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_cnt <= 0;
    end else if (out_valid) begin
      if (rcv_cnt >= sent_cnt) begin
        if (err_cnt < MAX_REPORTS)
          $display("%0t: result with nothing pending: status=%0d read_value=%h",
                   $time, out_payload.status, out_payload.read_value);
        err_cnt++;
      end else begin
        want = expected_replies[rcv_cnt];
        expected_replies.delete(rcv_cnt);
        rcv_cnt <= rcv_cnt + 1;
        if (out_payload.status !== want.status) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: status mismatch on transfer %0d: expected %0d, got %0d",
                     $time, rcv_cnt, want.status, out_payload.status);
          err_cnt++;
        end
        if (out_payload.read_value !== want.read_value) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: read_value mismatch on transfer %0d: expected %h, got %h",
                     $time, rcv_cnt, want.read_value, out_payload.read_value);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // directed: empty store, extreme keys and values, overwrite, misses, clear
    push_cmd(kvms_pkg::CMD_GET,    32'h0000_0000, '0, 1'b1);
    push_cmd(kvms_pkg::CMD_DELETE, 32'hFFFF_FFFF, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_CLEAR,  32'h0000_0000, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_SET,    32'h0000_0000, 64'h0, 1'b0);
    push_cmd(kvms_pkg::CMD_SET,    32'hFFFF_FFFF, '1, 1'b0);
    push_cmd(kvms_pkg::CMD_GET,    32'hFFFF_FFFF, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_GET,    32'h0000_0000, '1, 1'b0);
    push_cmd(kvms_pkg::CMD_SET,    32'h0000_0000, 64'h0123_4567_89AB_CDEF, 1'b0);
    push_cmd(kvms_pkg::CMD_GET,    32'h0000_0000, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_SET,    32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
    push_cmd(kvms_pkg::CMD_DELETE, 32'h0000_0000, '1, 1'b0);
    push_cmd(kvms_pkg::CMD_GET,    32'h0000_0000, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_DELETE, 32'h0000_0000, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_SET,    32'h0000_0001, 64'hFEDC_BA98_7654_3210, 1'b0);
    push_cmd(kvms_pkg::CMD_GET,    32'h5A5A_5A5A, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_GET,    32'h0000_0001, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_CLEAR,  32'hFFFF_FFFF, '1, 1'b0);
    push_cmd(kvms_pkg::CMD_GET,    32'hFFFF_FFFF, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_DELETE, 32'h5A5A_5A5A, '0, 1'b0);
    push_cmd(kvms_pkg::CMD_SET,    32'hFFFF_FFFF, 64'h0, 1'b0);
    push_cmd(kvms_pkg::CMD_GET,    32'hFFFF_FFFF, '1, 1'b0);

    // random: a fill session first so the full store is reached early
    fill_session();
    while (cmd_queue.size() < RAND_ITEMS + 21) begin
      if ($urandom_range(0, 3) == 0) fill_session();
      else mix_session($urandom_range(20, 60), $urandom_range(1, 48));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (cmd_queue.size() != 0 || start || sent_cnt != rcv_cnt) @(negedge clk);
    repeat (6) @(negedge clk);
    if (err_cnt == 0 && sent_cnt == rcv_cnt) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("%0t: timeout, %0d sent, %0d received", $time, sent_cnt, rcv_cnt);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
sv/kvms_pkg.sv
sv/kvms_ctrl.sv
sv/kvms_dpath.sv
sv/key_value_map_store.sv
sv/kvms_checker.sv
test/tb_top.sv
